// ----- rtl/json_string_field_extractor_macros.svh -----
// ---------------------------------------------------------------------------
// JSON string field extractor - assertion macros
// Shared property wrappers; all are clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define JSFE_ASSERT_IMP(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define JSFE_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/jsfe_pkg.sv -----
// ---------------------------------------------------------------------------
// JSON string field extractor - package
// Word types, result bundle, register indexes and status codes.
// ---------------------------------------------------------------------------
package jsfe_pkg;

   // defaults for top-level parameters
   localparam int MAX_KEY_LEN_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int KEY_W       = 64;
   localparam int KEY_LEN_W   = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int MAX_RESULTS = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LEN  = 2'd2;

   // status codes
   localparam logic [2:0] STAT_FOUND     = 3'd0;
   localparam logic [2:0] STAT_NO_KEY    = 3'd1;
   localparam logic [2:0] STAT_NO_COLON  = 3'd2;
   localparam logic [2:0] STAT_NOT_STR   = 3'd3;
   localparam logic [2:0] STAT_BAD_ESC   = 3'd4;
   localparam logic [2:0] STAT_UNTERM    = 3'd5;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       msg_last;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       is_status;
      logic [2:0] status;
   } rsp_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [1:0]                   last_idx;
      rsp_type [MAX_RESULTS-1:0]    item;
   } bundle_type;

endpackage

// ----- rtl/jsfe_front.sv -----
// ---------------------------------------------------------------------------
// JSON string field extractor - front end
// Takes one byte per cycle while the queue is not full, runs the key window
// match and value parser, and pushes each byte's results as one queue bundle.
// ---------------------------------------------------------------------------
module jsfe_front #(
   parameter int MAX_KEY_LEN = jsfe_pkg::MAX_KEY_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [jsfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jsfe_pkg::KEY_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  jsfe_pkg::req_type                   req_data,
   input  logic                                queue_full,
   output logic                                queue_push,
   output jsfe_pkg::bundle_type                queue_bundle
);

   localparam int WIN = MAX_KEY_LEN + 2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SPACE,
      PH_VALUE,
      PH_ESC,
      PH_HEX,
      PH_DONE
   } phase_type;

   // {valid, value} of one hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   logic [jsfe_pkg::KEY_W-1:0]     key_low_ff, key_high_ff;
   logic [jsfe_pkg::KEY_LEN_W-1:0] key_len_ff;
   logic [WIN-1:0][7:0]            win_ff, win_in;
   logic [4:0]                     seen_ff, seen_in;
   phase_type                      phase_ff, phase_in;
   logic [15:0]                    accum_ff, accum_in;
   logic [1:0]                     hexcnt_ff, hexcnt_in;

   logic                           accept;
   logic [7:0]                     b;
   logic                           last;
   logic [4:0]                     seen_cnt;
   logic [2*jsfe_pkg::KEY_W-1:0]   key_all;
   logic [jsfe_pkg::KEY_LEN_W-1:0] eff_len;
   logic [MAX_KEY_LEN:0]           match_len;
   logic                           match;
   logic [4:0]                     digit;
   logic [15:0]                    code;
   logic [3:0][7:0]                vals;
   logic [1:0]                     nvals;
   logic                           st_hit;
   logic [2:0]                     st_code;
   logic [2:0]                     nres;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.msg_byte;
   assign last      = req_data.msg_last;
   assign key_all   = {key_high_ff, key_low_ff};
   assign eff_len   = (key_len_ff > jsfe_pkg::KEY_LEN_W'(MAX_KEY_LEN)) ?
                      jsfe_pkg::KEY_LEN_W'(MAX_KEY_LEN) : key_len_ff;

   // window after this byte shifts in, and saturating byte count
   always_comb begin
      win_in[0] = b;
      for (int i = 1; i < WIN; i++) begin
         win_in[i] = win_ff[i-1];
      end
      seen_cnt = (seen_ff == 5'd31) ? seen_ff : seen_ff + 5'd1;
      // count restarts with the next message
      seen_in  = last ? 5'd0 : seen_cnt;
   end

   // quoted key compare, one candidate per key length
   always_comb begin
      for (int l = 0; l <= MAX_KEY_LEN; l++) begin
         match_len[l] = (win_in[0] == CH_QUOTE) && (win_in[l+1] == CH_QUOTE);
         for (int k = 0; k < l; k++) begin
            if (win_in[l-k] != key_all[8*k +: 8]) begin
               match_len[l] = 1'b0;
            end
         end
      end
      match = 1'b0;
      for (int l = 0; l <= MAX_KEY_LEN; l++) begin
         if (eff_len == jsfe_pkg::KEY_LEN_W'(l)) begin
            match = match_len[l];
         end
      end
      if (seen_cnt < eff_len + 5'd2) begin
         match = 1'b0;
      end
   end

   assign digit = hex_digit(b);
   assign code  = {accum_ff[11:0], digit[3:0]};

   // parser step
   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      hexcnt_in = hexcnt_ff;
      vals      = '0;
      nvals     = 2'd0;
      st_hit    = 1'b0;
      st_code   = jsfe_pkg::STAT_FOUND;

      case (phase_ff)
         PH_SEARCH: begin
            if (match) phase_in = PH_COLON;
         end
         PH_COLON: begin
            if (b == CH_COLON) phase_in = PH_SPACE;
         end
         PH_SPACE: begin
            if (b == CH_QUOTE) begin
               phase_in = PH_VALUE;
            end else if (b != CH_SPACE && b != CH_TAB) begin
               st_hit   = 1'b1;
               st_code  = jsfe_pkg::STAT_NOT_STR;
               phase_in = PH_DONE;
            end
         end
         PH_VALUE: begin
            if (b == CH_QUOTE) begin
               st_hit   = 1'b1;
               st_code  = jsfe_pkg::STAT_FOUND;
               phase_in = PH_DONE;
            end else if (b == CH_BSL && !last) begin
               phase_in = PH_ESC;
            end else begin
               vals[0] = b;
               nvals   = 2'd1;
            end
         end
         PH_ESC: begin
            phase_in = PH_VALUE;
            nvals    = 2'd1;
            case (b)
               CH_QUOTE, CH_BSL, CH_SLASH: vals[0] = b;
               CH_B: vals[0] = 8'h08;
               CH_F: vals[0] = 8'h0C;
               CH_N: vals[0] = 8'h0A;
               CH_R: vals[0] = 8'h0D;
               CH_T: vals[0] = 8'h09;
               CH_U: begin
                  nvals     = 2'd0;
                  phase_in  = PH_HEX;
                  accum_in  = 16'd0;
                  hexcnt_in = 2'd0;
               end
               default: begin
                  nvals    = 2'd0;
                  st_hit   = 1'b1;
                  st_code  = jsfe_pkg::STAT_BAD_ESC;
                  phase_in = PH_DONE;
               end
            endcase
         end
         PH_HEX: begin
            if (!digit[4]) begin
               st_hit   = 1'b1;
               st_code  = jsfe_pkg::STAT_BAD_ESC;
               phase_in = PH_DONE;
            end else begin
               accum_in = code;
               if (hexcnt_ff == 2'd3) begin
                  // code point to UTF-8
                  if (code < UTF_ONE_LIMIT) begin
                     vals[0] = code[7:0];
                     nvals   = 2'd1;
                  end else if (code < UTF_TWO_LIMIT) begin
                     vals[0] = {3'b110, code[10:6]};
                     vals[1] = {2'b10, code[5:0]};
                     nvals   = 2'd2;
                  end else begin
                     vals[0] = {4'b1110, code[15:12]};
                     vals[1] = {2'b10, code[11:6]};
                     vals[2] = {2'b10, code[5:0]};
                     nvals   = 2'd3;
                  end
                  hexcnt_in = 2'd0;
                  phase_in  = PH_VALUE;
               end else begin
                  hexcnt_in = hexcnt_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase

      // end of message without an earlier status
      if (last && !st_hit) begin
         case (phase_in)
            PH_SEARCH: begin
               st_hit = 1'b1; st_code = jsfe_pkg::STAT_NO_KEY;
            end
            PH_COLON: begin
               st_hit = 1'b1; st_code = jsfe_pkg::STAT_NO_COLON;
            end
            PH_SPACE: begin
               st_hit = 1'b1; st_code = jsfe_pkg::STAT_NOT_STR;
            end
            PH_VALUE, PH_ESC, PH_HEX: begin
               st_hit = 1'b1; st_code = jsfe_pkg::STAT_UNTERM;
            end
            default: ;
         endcase
      end

      if (last) begin
         phase_in  = PH_SEARCH;
         accum_in  = 16'd0;
         hexcnt_in = 2'd0;
      end
   end

   // bundle: value words first, then the status word
   always_comb begin
      nres = {1'b0, nvals} + {2'b00, st_hit};
      queue_bundle.last_idx = 2'(nres - 3'd1);
      for (int k = 0; k < jsfe_pkg::MAX_RESULTS; k++) begin
         if (2'(k) < nvals) begin
            queue_bundle.item[k].value_byte = vals[k];
            queue_bundle.item[k].is_status  = 1'b0;
            queue_bundle.item[k].status     = jsfe_pkg::STAT_FOUND;
         end else begin
            queue_bundle.item[k].value_byte = 8'd0;
            queue_bundle.item[k].is_status  = 1'b1;
            queue_bundle.item[k].status     = st_code;
         end
      end
   end

   assign queue_push = accept && (nres != 3'd0);

   // state and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= jsfe_pkg::KEY_LEN_W'(1);
         win_ff      <= '0;
         seen_ff     <= 5'd0;
         phase_ff    <= PH_SEARCH;
         accum_ff    <= 16'd0;
         hexcnt_ff   <= 2'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               jsfe_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
               jsfe_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               jsfe_pkg::CSR_KEY_LEN:  key_len_ff  <= csr_wdata[jsfe_pkg::KEY_LEN_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            win_ff    <= win_in;
            seen_ff   <= seen_in;
            phase_ff  <= phase_in;
            accum_ff  <= accum_in;
            hexcnt_ff <= hexcnt_in;
         end
      end
   end

endmodule

// ----- rtl/jsfe_fifo.sv -----
// ---------------------------------------------------------------------------
// JSON string field extractor - bundle queue
// Small register queue between front and back end.
// ---------------------------------------------------------------------------
module jsfe_fifo #(
   parameter int DEPTH = jsfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jsfe_pkg::bundle_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output jsfe_pkg::bundle_type  pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   jsfe_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- rtl/jsfe_back.sv -----
// ---------------------------------------------------------------------------
// JSON string field extractor - back end
// Unpacks queued bundles into single result words behind an output register.
// ---------------------------------------------------------------------------
module jsfe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_valid,
   input  jsfe_pkg::bundle_type  queue_data,
   output logic                  queue_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jsfe_pkg::rsp_type     rsp_data
);

   jsfe_pkg::bundle_type cur_ff;
   logic                 cur_valid_ff;
   logic [1:0]           idx_ff;
   logic                 rsp_valid_ff;
   jsfe_pkg::rsp_type    rsp_data_ff;

   logic out_free, take, cur_done;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = out_free && cur_valid_ff;
   assign cur_done  = take && (idx_ff == cur_ff.last_idx);
   assign queue_pop = queue_valid && (!cur_valid_ff || cur_done);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // current bundle and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (queue_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (take) begin
            cur_valid_ff <= !cur_done;
            idx_ff       <= idx_ff + 2'd1;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (queue_pop) cur_ff      <= queue_data;
      if (take)      rsp_data_ff <= cur_ff.item[idx_ff];
   end

endmodule

// ----- rtl/json_string_field_extractor.sv -----
// ---------------------------------------------------------------------------
// JSON string field extractor
// Finds a quoted key in a byte stream and returns the decoded string value.
// ---------------------------------------------------------------------------
// The block takes one message byte per cycle on req_ while the queue is not
// full and returns value bytes and then exactly one status word per message
// on rsp_, one word per cycle while rsp_ready is high. A byte normally yields
// zero or one word; a \uXXXX escape yields up to three UTF-8 bytes and, on the
// last byte of a message, a status as well, so one byte can cause up to four
// words. The front end parses every byte in the cycle it is taken; each byte's
// words sit as one entry in a QUEUE_DEPTH-entry queue, pass a current-bundle
// register and leave through a single output register, which sets the rate.
// Key registers are written through csr_; the user must do so only while no
// message is in flight, and the block has no check for it; no clearing pass.
// ---------------------------------------------------------------------------
`include "json_string_field_extractor_macros.svh"

module json_string_field_extractor #(
   parameter int MAX_KEY_LEN = jsfe_pkg::MAX_KEY_LEN_DEF,
   parameter int QUEUE_DEPTH = jsfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jsfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jsfe_pkg::KEY_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  jsfe_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output jsfe_pkg::rsp_type                 rsp_data
);

   logic                 queue_full, queue_push, queue_pop, queue_valid;
   jsfe_pkg::bundle_type push_bundle, pop_bundle;

   jsfe_front #(
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_full   (queue_full),
      .queue_push   (queue_push),
      .queue_bundle (push_bundle)
   );

   jsfe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_bundle),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (pop_bundle)
   );

   jsfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_data  (pop_bundle),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a full queue must hold off the input side
   `JSFE_ASSERT_IMP(a_full_stalls, queue_full, !req_ready, "byte taken while queue full")
   // a pushed bundle is visible to the back end next cycle
   `JSFE_ASSERT_NEXT(a_push_lands, queue_push, queue_valid, "pushed bundle lost")
   // status words carry a legal code and a zero value byte
   `JSFE_ASSERT_IMP(a_status_word, rsp_valid && rsp_data.is_status, (rsp_data.value_byte == 8'd0) && (rsp_data.status <= jsfe_pkg::STAT_UNTERM), "malformed status word")

endmodule
